// File: hdl/dgpid_pkg.sv
// ----------------------------------------------------------------------------
// dgpid_pkg
// shared types and constants for the dual gain pid controller
// ----------------------------------------------------------------------------
`default_nettype none

package dgpid_pkg;

    localparam int DATA_W     = 16;
    localparam int INTEG_W    = 32;
    localparam int DELTA_W    = DATA_W + 1;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int P_PROD_W   = GAIN_W + DATA_W;
    localparam int I_PROD_W   = GAIN_W + INTEG_W;
    localparam int D_PROD_W   = GAIN_W + DELTA_W;
    localparam int ACC_W      = I_PROD_W + 2;
    localparam int SHIFTED_W  = ACC_W - FRAC_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int MODE_W     = 2;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_STOP     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CURVE    = 2'd2;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KP_STRAIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KI_STRAIGHT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KD_STRAIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KP_CURVE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KI_CURVE    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_KD_CURVE    = 3'd6;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } gains_t;

    // one classified sample, handed from front to back
    typedef struct packed {
        logic                      hold;
        logic signed [DATA_W-1:0]  err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DELTA_W-1:0] delta;
        gains_t                    gains;
    } work_t;

endpackage

`default_nettype wire

// File: hdl/dgpid_front.sv
// ----------------------------------------------------------------------------
// dgpid_front
// accepts error samples, updates integral and previous error, picks gains
// ----------------------------------------------------------------------------
`default_nettype none

module dgpid_front
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [dgpid_pkg::DATA_W-1:0]  err,
    input  wire logic        [dgpid_pkg::MODE_W-1:0]  mode,
    input  wire dgpid_pkg::gains_t                    gains_straight,
    input  wire dgpid_pkg::gains_t                    gains_curve,
    output logic                                      push,
    output dgpid_pkg::work_t                          work,
    input  wire logic                                 queue_ready
);

    logic signed [dgpid_pkg::INTEG_W-1:0] integral_reg;
    logic signed [dgpid_pkg::INTEG_W-1:0] integral_next;
    logic signed [dgpid_pkg::DATA_W-1:0]  prev_err_reg;
    logic signed [dgpid_pkg::INTEG_W:0]   isum;
    logic                                 accept;

    assign in_ready = queue_ready;
    assign accept   = in_valid && queue_ready;
    assign push     = accept;

    always_comb
    begin
        isum = {integral_reg[dgpid_pkg::INTEG_W-1], integral_reg}
             + {{(dgpid_pkg::INTEG_W - dgpid_pkg::DATA_W + 1){err[dgpid_pkg::DATA_W-1]}}, err};
        // saturate when the two top bits disagree
        if (isum[dgpid_pkg::INTEG_W] != isum[dgpid_pkg::INTEG_W-1])
        begin
            integral_next = isum[dgpid_pkg::INTEG_W]
                ? {1'b1, {(dgpid_pkg::INTEG_W-1){1'b0}}}
                : {1'b0, {(dgpid_pkg::INTEG_W-1){1'b1}}};
        end
        else
        begin
            integral_next = isum[dgpid_pkg::INTEG_W-1:0];
        end
    end

    always_comb
    begin
        work.err   = err;
        work.integ = integral_next;
        work.delta = {err[dgpid_pkg::DATA_W-1], err}
                   - {prev_err_reg[dgpid_pkg::DATA_W-1], prev_err_reg};
        work.hold  = 1'b0;
        work.gains = gains_straight;
        case (mode)
            dgpid_pkg::MODE_STRAIGHT: work.gains = gains_straight;
            dgpid_pkg::MODE_CURVE:    work.gains = gains_curve;
            default:                  work.hold  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (accept)
        begin
            integral_reg <= integral_next;
            prev_err_reg <= err;
        end
    end

    // a non-negative sample never lowers the integral
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !err[dgpid_pkg::DATA_W-1]) |=> (integral_reg >= $past(integral_reg)))
        else $error("integral decreased on non-negative sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (prev_err_reg == $past(err)))
        else $error("previous error not updated");

endmodule

`default_nettype wire

// File: hdl/dgpid_queue.sv
// ----------------------------------------------------------------------------
// dgpid_queue
// short fifo of classified samples between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dgpid_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire dgpid_pkg::work_t wr_data,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dgpid_pkg::work_t      rd_data
);

    dgpid_pkg::work_t                   mem [dgpid_pkg::QUEUE_DEPTH];
    logic [dgpid_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [dgpid_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [dgpid_pkg::QUEUE_AW:0]       count_reg;
    logic                               pop;
    logic                               do_push;

    assign in_ready  = (count_reg != (dgpid_pkg::QUEUE_AW+1)'(dgpid_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign do_push   = push && in_ready;
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (dgpid_pkg::QUEUE_AW+1)'(dgpid_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// File: hdl/dgpid_back.sv
// ----------------------------------------------------------------------------
// dgpid_back
// two stage datapath: three products, then sum, shift and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module dgpid_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire dgpid_pkg::work_t                    work,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [dgpid_pkg::DATA_W-1:0]      drive
);

    logic                                     s1_valid_reg;
    logic                                     s1_hold_reg;
    logic signed [dgpid_pkg::P_PROD_W-1:0]    p_prod_reg;
    logic signed [dgpid_pkg::I_PROD_W-1:0]    i_prod_reg;
    logic signed [dgpid_pkg::D_PROD_W-1:0]    d_prod_reg;
    logic                                     out_valid_reg;
    logic signed [dgpid_pkg::DATA_W-1:0]      drive_reg;
    logic signed [dgpid_pkg::DATA_W-1:0]      drive_next;
    logic                                     out_free;
    logic                                     s1_load;
    logic                                     out_load;
    logic signed [dgpid_pkg::ACC_W-1:0]       acc;
    logic signed [dgpid_pkg::SHIFTED_W-1:0]   shifted;
    logic signed [dgpid_pkg::DATA_W-1:0]      sat;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign s1_load   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_hold_reg <= work.hold;
            p_prod_reg  <= work.gains.kp * work.err;
            i_prod_reg  <= work.gains.ki * work.integ;
            d_prod_reg  <= work.gains.kd * work.delta;
        end
    end

    always_comb
    begin
        acc = dgpid_pkg::ACC_W'(p_prod_reg)
            + dgpid_pkg::ACC_W'(i_prod_reg)
            + dgpid_pkg::ACC_W'(d_prod_reg);
        // arithmetic shift right rounds toward minus infinity
        shifted = acc[dgpid_pkg::ACC_W-1:dgpid_pkg::FRAC_W];
        if (shifted[dgpid_pkg::SHIFTED_W-1:dgpid_pkg::DATA_W-1]
            != {(dgpid_pkg::SHIFTED_W-dgpid_pkg::DATA_W+1){shifted[dgpid_pkg::SHIFTED_W-1]}})
        begin
            sat = shifted[dgpid_pkg::SHIFTED_W-1]
                ? {1'b1, {(dgpid_pkg::DATA_W-1){1'b0}}}
                : {1'b0, {(dgpid_pkg::DATA_W-1){1'b1}}};
        end
        else
        begin
            sat = shifted[dgpid_pkg::DATA_W-1:0];
        end
        // stop mode repeats the last computed drive
        drive_next = s1_hold_reg ? drive_reg : sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                drive_reg <= drive_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s1_hold_reg) |=> $stable(drive_reg))
        else $error("held drive changed in stop mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("product stage dropped a sample");

endmodule

`default_nettype wire

// File: hdl/dual_gain_pid_controller.sv
// ----------------------------------------------------------------------------
// dual_gain_pid_controller
// positional pid controller with straight and curve gain sets
// ----------------------------------------------------------------------------
// usage:
//   slave stream s_t* carries one signed 16-bit error sample per transaction;
//   master stream m_t* returns one signed 16-bit drive per sample, in order.
//   apb port holds mode (0 stop, 1 straight, 2 curve) and six q8.8 gains at
//   byte addresses 0x00..0x18; write only while no samples are in flight.
//   the front updates the saturating integral and previous error as each
//   sample is taken and queues it with the selected gains; the back forms
//   the three products in one stage and the sum, shift by 8 and clamp in
//   the next.
//   from an empty queue a sample passes a queue entry, the product and output
//   registers to m_tvalid. throughput: one sample per cycle while m_tready is
//   high, set by the integral update and the two stage product/sum pipeline.
//   when m_tready is low the output and product stages stall, the 4-entry
//   queue fills, then s_tready drops; nothing is lost or repeated.
//   reset: mode 1, gains 0, integral, previous error and held drive 0.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_gain_pid_controller
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,   // [15:0] error_sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,   // [15:0] drive
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dgpid_pkg::APB_AW-1:0]       paddr,
    input  wire logic [dgpid_pkg::APB_DW-1:0]       pwdata,
    output logic [dgpid_pkg::APB_DW-1:0]            prdata,
    output logic                                    pready
);

    logic [dgpid_pkg::MODE_W-1:0]       mode_reg;
    dgpid_pkg::gains_t                  straight_reg;
    dgpid_pkg::gains_t                  curve_reg;
    logic                               cfg_write;
    logic [dgpid_pkg::REG_IDX_W-1:0]    reg_idx;
    logic [dgpid_pkg::GAIN_W-1:0]       wgain;

    logic                               front_push;
    dgpid_pkg::work_t                   front_work;
    logic                               queue_in_ready;
    logic                               queue_valid;
    dgpid_pkg::work_t                   queue_work;
    logic                               back_ready;
    logic signed [dgpid_pkg::DATA_W-1:0] drive;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[dgpid_pkg::REG_IDX_W+1:2];
    assign wgain     = pwdata[dgpid_pkg::GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= dgpid_pkg::MODE_STRAIGHT;
            straight_reg <= '0;
            curve_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                dgpid_pkg::REG_MODE:        mode_reg        <= pwdata[dgpid_pkg::MODE_W-1:0];
                dgpid_pkg::REG_KP_STRAIGHT: straight_reg.kp <= wgain;
                dgpid_pkg::REG_KI_STRAIGHT: straight_reg.ki <= wgain;
                dgpid_pkg::REG_KD_STRAIGHT: straight_reg.kd <= wgain;
                dgpid_pkg::REG_KP_CURVE:    curve_reg.kp    <= wgain;
                dgpid_pkg::REG_KI_CURVE:    curve_reg.ki    <= wgain;
                dgpid_pkg::REG_KD_CURVE:    curve_reg.kd    <= wgain;
                default:                    mode_reg        <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            dgpid_pkg::REG_MODE:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::MODE_W){1'b0}}, mode_reg};
            dgpid_pkg::REG_KP_STRAIGHT:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::GAIN_W){1'b0}}, straight_reg.kp};
            dgpid_pkg::REG_KI_STRAIGHT:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::GAIN_W){1'b0}}, straight_reg.ki};
            dgpid_pkg::REG_KD_STRAIGHT:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::GAIN_W){1'b0}}, straight_reg.kd};
            dgpid_pkg::REG_KP_CURVE:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::GAIN_W){1'b0}}, curve_reg.kp};
            dgpid_pkg::REG_KI_CURVE:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::GAIN_W){1'b0}}, curve_reg.ki};
            dgpid_pkg::REG_KD_CURVE:
                prdata = {{(dgpid_pkg::APB_DW-dgpid_pkg::GAIN_W){1'b0}}, curve_reg.kd};
            default:
                prdata = '0;
        endcase
    end

    dgpid_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .err            (s_tdata),
        .mode           (mode_reg),
        .gains_straight (straight_reg),
        .gains_curve    (curve_reg),
        .push           (front_push),
        .work           (front_work),
        .queue_ready    (queue_in_ready)
    );

    dgpid_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .wr_data   (front_work),
        .in_ready  (queue_in_ready),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .rd_data   (queue_work)
    );

    dgpid_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .work      (queue_work),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (drive)
    );

    assign m_tdata = drive;

endmodule

`default_nettype wire
